>>> hw/rtl/rraa_pkg.sv
// shared types, widths and codes of the rounded rectangle rasterizer
package rraa_pkg;

  localparam int FRAC_BITS = 6;
  localparam int ONE_Q     = 64;

  // corner math widths
  localparam int AB_W   = 14;   // ellipse axis in q6
  localparam int AX_W   = 16;   // distance from the corner center
  localparam int SQ_W   = 28;   // axis squared
  localparam int DS_W   = 32;   // distance squared
  localparam int D_W    = 33;   // dx^2 + dy^2
  localparam int PR_W   = 60;
  localparam int M_W    = 56;   // a^2 * b^2
  localparam int E_W    = 61;   // a^2*dy^2 + b^2*dx^2
  localparam int MD_W   = 61;   // partial product of a^2*b^2 and d
  localparam int RHS_W  = 89;
  localparam int CAND_W = 93;
  localparam int Q_W    = 76;
  localparam int K_W    = 15;
  localparam int ROOT_W = 34;
  localparam int DIS_W  = 17;

  localparam int BACK_STAGES = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_STROKE   = 2'd1,
    REGION_ARC      = 2'd2,
    REGION_BACK     = 2'd3
  } region_t;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MARGIN       = 3'd2;
  localparam logic [2:0] REG_STROKE_WIDTH = 3'd3;
  localparam logic [2:0] REG_CORNER_RADII = 3'd4;
  localparam logic [2:0] REG_STROKE_COLOR = 3'd5;
  localparam logic [2:0] REG_BACK_COLOR   = 3'd6;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [7:0]  margin_px;
    logic [11:0] stroke_width_q6;
    logic [31:0] corner_radii;
    logic [23:0] stroke_color;
    logic [23:0] back_color;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:     11'd10,
    frame_height:    11'd10,
    margin_px:       8'd1,
    stroke_width_q6: 12'd64,
    corner_radii:    32'd0,
    stroke_color:    24'h777777,
    back_color:      24'h000000
  };

  // classified pixel handed from front to back, color index 0 is blue
  typedef struct packed {
    region_t             mode;
    logic                zero;
    logic                far;
    logic [AB_W-1:0]     a;
    logic [AB_W-1:0]     b;
    logic [AB_W-1:0]     ai;
    logic [AB_W-1:0]     bi;
    logic [AX_W-1:0]     ax;
    logic [AX_W-1:0]     ay;
    logic [2:0][7:0]     fill;
  } front_item_t;

endpackage

>>> hw/rtl/rraa_front.sv
// front end: region classification and corner geometry per pixel
module rraa_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rraa_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_BITS-1:0]     pixel_x,
  input  logic [COORD_BITS-1:0]     pixel_y,
  input  logic [7:0]                inner_red,
  input  logic [7:0]                inner_green,
  input  logic [7:0]                inner_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rraa_pkg::front_item_t     out_item
);
  import rraa_pkg::*;

  localparam int GW = ((COORD_BITS > 11) ? COORD_BITS : 11) + FRAC_BITS + 3;
  localparam logic signed [GW-1:0] ONEQ  = GW'(ONE_Q);
  localparam logic signed [GW-1:0] FMASK = GW'(ONE_Q - 1);

  function automatic logic signed [GW-1:0] flr(input logic signed [GW-1:0] v);
    return v & ~FMASK;
  endfunction

  function automatic logic signed [GW-1:0] cel(input logic signed [GW-1:0] v);
    return flr(v + FMASK);
  endfunction

  logic signed [GW-1:0] ux, uy, lum, sw, swc, uw, uh, r1, r2, r3, r4;
  logic signed [GW-1:0] tw, th, rx1, ry1, cxs, cys, ccx, ccy;
  logic signed [GW-1:0] dx, dy, adx, ady, ti, tj;
  region_t     mode;
  front_item_t item_nxt, item_r;
  logic        valid_r, valid_nxt;

  assign ux  = $signed(GW'(pixel_x) << FRAC_BITS);
  assign uy  = $signed(GW'(pixel_y) << FRAC_BITS);
  assign lum = $signed(GW'(cfg.margin_px) << FRAC_BITS);
  assign sw  = $signed(GW'(cfg.stroke_width_q6));
  assign swc = cel(sw);
  assign uw  = $signed(GW'(cfg.frame_width) << FRAC_BITS);
  assign uh  = $signed(GW'(cfg.frame_height) << FRAC_BITS);
  assign r1  = $signed(GW'(cfg.corner_radii[31:24]) << FRAC_BITS);
  assign r2  = $signed(GW'(cfg.corner_radii[23:16]) << FRAC_BITS);
  assign r3  = $signed(GW'(cfg.corner_radii[15:8]) << FRAC_BITS);
  assign r4  = $signed(GW'(cfg.corner_radii[7:0]) << FRAC_BITS);

  // top-left corner is limited by the frame minus the stroke
  assign tw  = uw - sw;
  assign th  = uh - sw;
  assign rx1 = (tw < 0) ? '0 : ((tw < r1) ? tw : r1);
  assign ry1 = (th < 0) ? '0 : ((th < r1) ? th : r1);

  always_comb begin
    mode = REGION_INTERIOR;
    cxs  = '0;
    cys  = '0;
    ccx  = '0;
    ccy  = '0;
    if (ux < cel(rx1 + lum) && uy < cel(ry1 + lum)) begin
      mode = REGION_ARC;
      cxs  = rx1;
      cys  = ry1;
      ccx  = rx1 - ONEQ + lum;
      ccy  = ry1 - ONEQ + lum;
    end else if (ux > cel(uw - r2 - lum) && uy < cel(r2 + lum)) begin
      mode = REGION_ARC;
      cxs  = r2;
      cys  = r2;
      ccx  = uw - r2 - lum;
      ccy  = r2 - ONEQ + lum;
    end else if (ux > cel(uw - r3 - lum) && uy > flr(uh - r3 - lum)) begin
      mode = REGION_ARC;
      cxs  = r3;
      cys  = r3;
      ccx  = uw - r3 - lum;
      ccy  = uh - r3 - lum;
    end else if (ux < cel(r4 + lum) && uy > flr(uh - r4 - lum)) begin
      mode = REGION_ARC;
      cxs  = r4;
      cys  = r4;
      ccx  = r4 - ONEQ + lum;
      ccy  = uh - r4 - lum;
    end else if (uy < swc - ONEQ + lum) begin
      mode = (uy < lum - ONEQ) ? REGION_BACK : REGION_STROKE;
    end else if (ux > uw - swc - lum) begin
      mode = (ux > uw - lum) ? REGION_BACK : REGION_STROKE;
    end else if (uy > uh - swc - lum) begin
      mode = (uy > uh - lum) ? REGION_BACK : REGION_STROKE;
    end else if (ux < swc - ONEQ + lum) begin
      mode = (ux < lum - ONEQ) ? REGION_BACK : REGION_STROKE;
    end
  end

  assign dx  = ux - ccx;
  assign dy  = uy - ccy;
  assign adx = (dx < 0) ? -dx : dx;
  assign ady = (dy < 0) ? -dy : dy;
  assign ti  = cxs - sw;
  assign tj  = cys - sw;

  always_comb begin
    item_nxt.mode    = mode;
    item_nxt.zero    = (adx == 0) && (ady == 0);
    item_nxt.far     = (|adx[GW-1:AX_W]) || (|ady[GW-1:AX_W]);
    item_nxt.a       = cxs[AB_W-1:0];
    item_nxt.b       = cys[AB_W-1:0];
    item_nxt.ai      = (ti < 0) ? '0 : ti[AB_W-1:0];
    item_nxt.bi      = (tj < 0) ? '0 : tj[AB_W-1:0];
    item_nxt.ax      = adx[AX_W-1:0];
    item_nxt.ay      = ady[AX_W-1:0];
    item_nxt.fill[0] = inner_blue;
    item_nxt.fill[1] = inner_green;
    item_nxt.fill[2] = inner_red;
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> hw/rtl/rraa_queue.sv
// short item queue between the front and the back
module rraa_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  rraa_pkg::front_item_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output rraa_pkg::front_item_t pop_data
);
  import rraa_pkg::*;

  front_item_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/rraa_back.sv
// back end: polar radius, distance root, blend and color select pipeline
module rraa_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rraa_pkg::cfg_t        cfg,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  rraa_pkg::front_item_t item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [23:0]           res_color,
  output rraa_pkg::region_t     res_region
);
  import rraa_pkg::*;

  typedef struct packed {
    region_t               mode;
    logic                  zero;
    logic                  far;
    logic [AB_W-1:0]       a;
    logic [AB_W-1:0]       b;
    logic [AB_W-1:0]       ai;
    logic [AB_W-1:0]       bi;
    logic [AX_W-1:0]       ax;
    logic [AX_W-1:0]       ay;
    logic [2:0][7:0]       fill;
    logic [SQ_W-1:0]       a2;
    logic [SQ_W-1:0]       b2;
    logic [SQ_W-1:0]       ai2;
    logic [SQ_W-1:0]       bi2;
    logic [DS_W-1:0]       ax2;
    logic [DS_W-1:0]       ay2;
    logic [PR_W-1:0]       pa;
    logic [PR_W-1:0]       pb;
    logic [PR_W-1:0]       pai;
    logic [PR_W-1:0]       pbi;
    logic [M_W-1:0]        m;
    logic [M_W-1:0]        mi;
    logic [D_W-1:0]        d;
    logic [E_W-1:0]        e;
    logic [E_W-1:0]        ei;
    logic [MD_W-1:0]       mlo;
    logic [MD_W-1:0]       mhi;
    logic [MD_W-1:0]       mloi;
    logic [MD_W-1:0]       mhii;
    logic [RHS_W-1:0]      rhs;
    logic [RHS_W-1:0]      rhsi;
    logic [RHS_W-1:0]      p_o;
    logic [RHS_W-1:0]      p_i;
    logic [Q_W-1:0]        q_o;
    logic [Q_W-1:0]        q_i;
    logic [K_W-1:0]        k_o;
    logic [K_W-1:0]        k_i;
    logic [D_W-1:0]        sv;
    logic [ROOT_W-1:0]     sr;
    logic [2:0][15:0]      mix;
    logic [2:0][7:0]       res;
  } back_stage_t;

  back_stage_t             st_in;
  back_stage_t             st_r [1:BACK_STAGES];
  logic [BACK_STAGES:1]    vld_r;
  logic                    adv;
  logic [2:0][7:0]         strk, bkg;

  assign strk       = cfg.stroke_color;
  assign bkg        = cfg.back_color;
  // whole pipeline moves together, held only by the output stage
  assign adv        = !vld_r[BACK_STAGES] || res_ready;
  assign item_ready = adv;

  always_comb begin
    st_in      = '0;
    st_in.mode = item.mode;
    st_in.zero = item.zero;
    st_in.far  = item.far;
    st_in.a    = item.a;
    st_in.b    = item.b;
    st_in.ai   = item.ai;
    st_in.bi   = item.bi;
    st_in.ax   = item.ax;
    st_in.ay   = item.ay;
    st_in.fill = item.fill;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BACK_STAGES-1:1], item_valid};
    end
  end

  for (genvar g = 1; g <= BACK_STAGES; g++) begin : g_stage
    localparam int SB = (g >= 5 && g <= 19) ? 19 - g : 0;
    localparam int IB = (g >= 3 && g <= 19) ? 32 - 2 * (g - 3) : 0;

    back_stage_t prv, nxt;

    if (g == 1) begin : g_head
      assign prv = st_in;
    end else begin : g_link
      assign prv = st_r[g-1];
    end

    always_comb begin
      logic [ROOT_W-1:0] vv, rv, trial;
      logic [CAND_W-1:0] cand, candi;
      logic [17:0]       dis, rad, irad, rem;
      logic [7:0]        c, w;
      logic [2:0][7:0]   first, second;
      region_t           md;
      logic [16:0]       sum;

      nxt = prv;
      vv = '0;
      rv = '0;
      trial = '0;
      cand = '0;
      candi = '0;
      dis = '0;
      rad = '0;
      irad = '0;
      rem = '0;
      c = '0;
      w = '0;
      first = '0;
      second = '0;
      md = prv.mode;
      sum = '0;

      if (g == 1) begin
        nxt.a2  = SQ_W'(prv.a) * SQ_W'(prv.a);
        nxt.b2  = SQ_W'(prv.b) * SQ_W'(prv.b);
        nxt.ai2 = SQ_W'(prv.ai) * SQ_W'(prv.ai);
        nxt.bi2 = SQ_W'(prv.bi) * SQ_W'(prv.bi);
        nxt.ax2 = DS_W'(prv.ax) * DS_W'(prv.ax);
        nxt.ay2 = DS_W'(prv.ay) * DS_W'(prv.ay);
      end

      if (g == 2) begin
        nxt.pa  = PR_W'(prv.a2) * PR_W'(prv.ay2);
        nxt.pb  = PR_W'(prv.b2) * PR_W'(prv.ax2);
        nxt.pai = PR_W'(prv.ai2) * PR_W'(prv.ay2);
        nxt.pbi = PR_W'(prv.bi2) * PR_W'(prv.ax2);
        nxt.m   = M_W'(prv.a2) * M_W'(prv.b2);
        nxt.mi  = M_W'(prv.ai2) * M_W'(prv.bi2);
        nxt.d   = D_W'(prv.ax2) + D_W'(prv.ay2);
      end

      if (g == 3) begin
        nxt.e    = E_W'(prv.pa) + E_W'(prv.pb);
        nxt.ei   = E_W'(prv.pai) + E_W'(prv.pbi);
        nxt.mlo  = MD_W'(prv.m[27:0]) * MD_W'(prv.d);
        nxt.mhi  = MD_W'(prv.m[55:28]) * MD_W'(prv.d);
        nxt.mloi = MD_W'(prv.mi[27:0]) * MD_W'(prv.d);
        nxt.mhii = MD_W'(prv.mi[55:28]) * MD_W'(prv.d);
      end

      if (g == 4) begin
        nxt.rhs  = (RHS_W'(prv.mhi) << 28) + RHS_W'(prv.mlo);
        nxt.rhsi = (RHS_W'(prv.mhii) << 28) + RHS_W'(prv.mloi);
        nxt.p_o  = '0;
        nxt.p_i  = '0;
        nxt.q_o  = '0;
        nxt.q_i  = '0;
        nxt.k_o  = '0;
        nxt.k_i  = '0;
      end

      // square root of the distance, two bits of radicand per stage
      if (g >= 3 && g <= 19) begin
        if (g == 3) begin
          vv = ROOT_W'(prv.d);
          rv = '0;
        end else begin
          vv = ROOT_W'(prv.sv);
          rv = prv.sr;
        end
        trial = rv + (ROOT_W'(1) << IB);
        if (vv >= trial) begin
          nxt.sv = D_W'(vv - trial);
          nxt.sr = (rv >> 1) + (ROOT_W'(1) << IB);
        end else begin
          nxt.sv = D_W'(vv);
          nxt.sr = rv >> 1;
        end
      end

      // radius bit search, squares kept incrementally: (k+2^b)^2 e
      if (g >= 5 && g <= 19) begin
        cand = CAND_W'(prv.p_o) + (CAND_W'(prv.q_o) << (SB + 1)) +
               (CAND_W'(prv.e) << (2 * SB));
        if (cand <= CAND_W'(prv.rhs)) begin
          nxt.p_o     = cand[RHS_W-1:0];
          nxt.q_o     = prv.q_o + (Q_W'(prv.e) << SB);
          nxt.k_o[SB] = 1'b1;
        end
        candi = CAND_W'(prv.p_i) + (CAND_W'(prv.q_i) << (SB + 1)) +
                (CAND_W'(prv.ei) << (2 * SB));
        if (candi <= CAND_W'(prv.rhsi)) begin
          nxt.p_i     = candi[RHS_W-1:0];
          nxt.q_i     = prv.q_i + (Q_W'(prv.ei) << SB);
          nxt.k_i[SB] = 1'b1;
        end
      end

      if (g == 20) begin
        dis  = 18'(prv.sr[DIS_W-1:0]);
        rad  = (prv.a == '0 || prv.b == '0) ? '0 : 18'(prv.k_o);
        irad = (prv.ai == '0 || prv.bi == '0) ? '0 : 18'(prv.k_i);
        first = prv.fill;
        second = prv.fill;
        case (prv.mode)
          REGION_INTERIOR: first = prv.fill;
          REGION_STROKE:   first = strk;
          REGION_ARC: begin
            if (prv.zero) begin
              first = prv.fill;
            end else if (prv.far) begin
              md = REGION_BACK;
            end else if (dis >= rad + 18'(ONE_Q)) begin
              md = REGION_BACK;
            end else if (dis >= rad) begin
              // outer edge, stroke fading into background
              rem    = dis - rad;
              first  = strk;
              second = bkg;
              c      = {rem[5:0], 2'b00};
            end else if (dis >= irad + 18'(ONE_Q)) begin
              first = strk;
            end else if (dis <= irad) begin
              first = prv.fill;
            end else begin
              rem    = dis - irad;
              first  = prv.fill;
              second = strk;
              c      = {rem[5:0], 2'b00};
            end
          end
          default: md = REGION_BACK;
        endcase
        if (md == REGION_BACK) begin
          first = bkg;
          c     = '0;
        end
        w = 8'd255 - c;
        nxt.mode = md;
        for (int ch = 0; ch < 3; ch++) begin
          nxt.mix[ch] = 16'(w) * 16'(first[ch]) + 16'(c) * 16'(second[ch]);
        end
      end

      // divide by 255 with a shift-add correction
      if (g == 21) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum = 17'(prv.mix[ch]) + 17'd1 + 17'(prv.mix[ch][15:8]);
          nxt.res[ch] = sum[15:8];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= nxt;
      end
    end
  end

  assign res_valid  = vld_r[BACK_STAGES];
  assign res_color  = st_r[BACK_STAGES].res;
  assign res_region = st_r[BACK_STAGES].mode;

endmodule

>>> hw/rtl/rounded_rect_aa_rasterizer_core.sv
// Rounded rectangle rasterizer: one pixel per clock, sustained while the output
// is not stalled. An input item is a pixel coordinate with its fill color; the
// result is that pixel's color and region code. An accepted item passes one
// classification register, one queue slot, then a 21-stage pipeline set mostly
// by the 15-step radius bit search. A four-entry queue sits
// between classification and the arithmetic pipeline. Configuration is taken at
// any time and must only be written while no pixel is in flight.
module rounded_rect_aa_rasterizer_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // pixel_x, pixel_y, inner_red, inner_green, inner_blue, zero pad
  input  logic [((2*COORD_BITS+31)/8)*8-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // out_blue, out_green, out_red
  output logic [23:0]                             out_tdata,
  // region
  output logic [1:0]                              out_tuser,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [2:0]                              cfg_index,
  input  logic [31:0]                             cfg_data
);
  import rraa_pkg::*;

  localparam int CB = COORD_BITS;

  cfg_t        cfg_r;
  logic        f_valid, f_ready, q_valid, q_ready;
  front_item_t f_item, q_item;
  region_t     res_region;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg_r.frame_width     <= cfg_data[10:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height    <= cfg_data[10:0];
        REG_MARGIN:       cfg_r.margin_px       <= cfg_data[7:0];
        REG_STROKE_WIDTH: cfg_r.stroke_width_q6 <= cfg_data[11:0];
        REG_CORNER_RADII: cfg_r.corner_radii    <= cfg_data;
        REG_STROKE_COLOR: cfg_r.stroke_color    <= cfg_data[23:0];
        REG_BACK_COLOR:   cfg_r.back_color      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  rraa_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pixel_x     (in_tdata[CB-1:0]),
    .pixel_y     (in_tdata[2*CB-1:CB]),
    .inner_red   (in_tdata[2*CB+7:2*CB]),
    .inner_green (in_tdata[2*CB+15:2*CB+8]),
    .inner_blue  (in_tdata[2*CB+23:2*CB+16]),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_item    (f_item)
  );

  rraa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_item)
  );

  rraa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_color  (out_tdata),
    .res_region (res_region)
  );

  assign out_tuser = res_region;

endmodule

>>> hw/rtl/rraa_checker.sv
// port-level checks of the rasterizer core and their bind
module rraa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data
);
  import rraa_pkg::*;

  logic [23:0] strk_r, back_r;

  // shadow of the two color registers as written through the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strk_r <= CFG_RESET.stroke_color;
      back_r <= CFG_RESET.back_color;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STROKE_COLOR) begin
        strk_r <= cfg_data[23:0];
      end
      if (cfg_index == REG_BACK_COLOR) begin
        back_r <= cfg_data[23:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_back_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REGION_BACK |-> out_tdata == back_r)
    else $error("background item without background color");

  a_stroke_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REGION_STROKE |-> out_tdata == strk_r)
    else $error("stroke side item without stroke color");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind rounded_rect_aa_rasterizer_core rraa_checker u_rraa_checker (.*);
